@@ hw/rtl/breakpoint_exponential_envelope_top_assert.svh @@
// assertion macros for the breakpoint envelope checker
// no dependencies; included by the checker file
`ifndef BREAKPOINT_EXPONENTIAL_ENVELOPE_TOP_ASSERT_SVH
`define BREAKPOINT_EXPONENTIAL_ENVELOPE_TOP_ASSERT_SVH

// implication into the next cycle, off while reset is high
`define BPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication into the next cycle, active through reset
`define BPE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bpe_pkg.sv @@
// shared types, constants and the exponent root table of the envelope block
// no dependencies
`timescale 1ns / 1ps

package bpe_pkg;

   localparam int LOG_FRAC = 24;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
   localparam logic [31:0] EPS_Q30 = 32'd107374;
   localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
   localparam logic [15:0] STRETCH_ONE = 16'd4096;
   localparam logic [31:0] EXP_BIAS = 32'd32 << LOG_FRAC;
   localparam logic [63:0] Q_HIGH = 64'd2 << LOG_FRAC;
   localparam logic [63:0] Q_LOW = 64'd31 << LOG_FRAC;

   // register indexes
   localparam logic [2:0] CSR_POINT_COUNT = 3'd0;
   localparam logic [2:0] CSR_PAIR_0 = 3'd1;
   localparam logic [2:0] CSR_PAIR_1 = 3'd2;
   localparam logic [2:0] CSR_PAIR_2 = 3'd3;
   localparam logic [2:0] CSR_PAIR_3 = 3'd4;

   typedef struct packed {
      logic        restart;
      logic [15:0] stretch;
   } req_type;

   typedef struct packed {
      logic [15:0] level;
      logic        done_res;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   function automatic logic [31:0] isqrt64(input logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] bit_v;
      a = a_in;
      r = 64'd0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (a >= r + bit_v) begin
            a = a - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r[31:0];
   endfunction

   // repeated square roots of 2.0 in q2.30
   function automatic logic [LOG_FRAC:0][31:0] build_roots();
      logic [LOG_FRAC:0][31:0] t;
      t[0] = 32'h8000_0000;
      for (int i = 1; i <= LOG_FRAC; i++) begin
         t[i] = isqrt64({32'd0, t[i-1]} << 30);
      end
      return t;
   endfunction

   localparam logic [LOG_FRAC:0][31:0] ROOT_TAB = build_roots();

endpackage

@@ hw/rtl/bpe_mul.sv @@
// bit-serial 32 x 32 unsigned shift-add multiplier
// depends on bpe_pkg
`timescale 1ns / 1ps

module bpe_mul (
   input  logic                clock,
   input  logic                reset,
   input  bpe_pkg::mul_req_type mul_req,
   output logic                done,
   output logic [63:0]         product
);
   import bpe_pkg::*;

   logic [31:0] mcand_ff, mcand_in;
   logic [63:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] sum;

   always_comb begin
      sum = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, mcand_ff} : 33'd0);
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         mcand_in = mul_req.a;
         acc_in = {32'd0, mul_req.b};
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add on the low multiplier bit, then shift one place
         acc_in = {sum, acc_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

@@ hw/rtl/bpe_div.sv @@
// bit-serial restoring divider, 64-bit dividend by 32-bit divisor
// depends on bpe_pkg
`timescale 1ns / 1ps

module bpe_div (
   input  logic                clock,
   input  logic                reset,
   input  bpe_pkg::div_req_type div_req,
   output logic                done,
   output logic [63:0]         quotient
);
   import bpe_pkg::*;

   logic [31:0] dvsr_ff, dvsr_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   always_comb begin
      trial = {rem_ff, quo_ff[63]};
      diff = trial - {1'b0, dvsr_ff};
      fits = (trial >= {1'b0, dvsr_ff});
      dvsr_in = dvsr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvsr_in = div_req.divisor;
         rem_in = 32'd0;
         quo_in = div_req.dividend;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, dividend shifts out as quotient shifts in
         rem_in = fits ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvsr_ff <= dvsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/breakpoint_exponential_envelope_top.sv @@
// multi-segment exponential envelope: sequencer, breakpoint registers, ratio math
// depends on bpe_pkg, bpe_mul, bpe_div
`timescale 1ns / 1ps

// usage
// - req channel: one beat per sample tick (restart flag, stretch factor)
// - rsp channel: one beat per req beat (level, done_res), in order
// - csr port: write point_count (index 0) and the four breakpoint pairs
//   (index 1..4) while idle; any write to these indexes reloads the start
//   value and returns to segment 0
// - a tick inside a segment runs one serial multiply on the shared
//   shift-add multiplier
// - a tick that loads a segment runs a length multiply, a division, a
//   leading-one walk, 24 serial squarings, a second division and up to
//   24 serial root multiplies; an empty or flat segment, a zero start
//   value or a saturated ratio ends the chain sooner
// - a tick past the last segment goes straight from accept through S_OUT
//   into the rsp register, with no multiply or division
// - one tick is in work at a time; the next req beat is taken as soon as
//   the result sits in the rsp register, even while rsp is stalled
// - rsp_stall holds the rsp register; the block then finishes at most one
//   more tick and waits with req_stall high
// - synchronous reset: no beats in flight, level 1.0, segment 0

module breakpoint_exponential_envelope_top #(
   parameter int MAX_POINTS = 8,
   parameter int TIME_BITS  = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bpe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bpe_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import bpe_pkg::*;

   // effective field widths inside a 16-bit breakpoint slot half
   localparam int TW = (TIME_BITS < 16) ? TIME_BITS : 16;
   localparam int VW = (VALUE_BITS < 16) ? VALUE_BITS : 16;
   localparam int VSHIFT = 32 - VALUE_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_TICK, S_RD0, S_RD1, S_LEN, S_DIV1, S_NORM,
      S_SQ, S_DIV2, S_EXP, S_SCALE, S_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic        wait_ff, wait_in;
   logic [3:0]  count_ff, count_in;
   logic [3:0][63:0] pair_ff, pair_in;
   logic [3:0]  idx_ff, idx_in;
   logic [23:0] len_ff, len_in;
   logic [23:0] pos_ff, pos_in;
   logic [31:0] env_ff, env_in;
   logic [31:0] ratio_ff, ratio_in;
   logic [15:0] stretch_ff, stretch_in;
   logic [TW-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [VW-1:0] v0_ff, v0_in, v1_ff, v1_in;
   logic [63:0] x_ff, x_in;
   logic [5:0]  lead_ff, lead_in;
   logic [31:0] m_ff, m_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [4:0]  iter_ff, iter_in;
   logic [31:0] lmag_ff, lmag_in;
   logic        lneg_ff, lneg_in;
   logic [5:0]  expo_ff, expo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // breakpoint view: slot k is point k, time low half, value high half
   logic [7:0][31:0]   slots;
   logic [7:0][VW-1:0] pt_val;
   logic [6:0]         rise;
   logic [3:0]         n_used;
   logic [2:0]         rd_addr;
   logic [31:0]        rd_slot;
   logic               ahead;
   logic [TW-1:0]      diff_t;

   mul_req_type mul_req;
   div_req_type div_req;
   logic        mul_done, div_done;
   logic [63:0] mul_prod, div_quot;

   logic        accept;
   logic [3:0]  idx_e;
   logic [23:0] len_e, pos_e, len_new;
   logic [33:0] sq_full;
   logic [31:0] tick_val;
   logic [31:0] u_val;
   logic [32:0] scaled;
   logic [3:0]  n_new;

   function automatic logic [31:0] to_q30(input logic [VW-1:0] v);
      return 32'(v) << VSHIFT;
   endfunction

   function automatic logic [3:0] clamp_count(input logic [3:0] c);
      return (c > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : c;
   endfunction

   bpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_prod)
   );

   bpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign slots = pair_ff;
   assign n_used = clamp_count(count_ff);
   assign rd_addr = (state_ff == S_RD1) ? (idx_ff[2:0] + 3'd1) : idx_ff[2:0];
   assign rd_slot = slots[rd_addr];
   assign diff_t = (t1_ff > t0_ff) ? (t1_ff - t0_ff) : '0;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // rising pair flags at fixed places, masked by the current index and point count
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         pt_val[k] = slots[k][16 +: VW];
      end
      for (int k = 0; k < 7; k++) begin
         rise[k] = (pt_val[k] < pt_val[k+1]);
      end
      ahead = 1'b0;
      for (int k = 0; k < 7; k++) begin
         if ((4'(k) >= idx_ff) && (4'(k + 2) < n_used) && rise[k]) begin
            ahead = 1'b1;
         end
      end
   end

   // operand selection for the shared units
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a = env_ff;
      mul_req.b = ratio_ff;
      div_req.start = 1'b0;
      div_req.dividend = 64'(v1_ff) << 30;
      div_req.divisor = 32'(v0_ff);
      unique case (state_ff)
         S_LEN: begin
            mul_req.a = 32'(diff_t);
            mul_req.b = 32'(stretch_ff);
         end
         S_SQ: begin
            mul_req.a = m_ff;
            mul_req.b = m_ff;
         end
         S_EXP: begin
            mul_req.a = m_ff;
            mul_req.b = ROOT_TAB[iter_ff];
         end
         S_DIV2: begin
            div_req.dividend = 64'(lmag_ff);
            div_req.divisor = 32'(len_ff);
         end
         default: ;
      endcase
      if (!wait_ff) begin
         mul_req.start = (state_ff == S_TICK) || (state_ff == S_LEN) || (state_ff == S_SQ)
                         || ((state_ff == S_EXP) && frac_ff[LOG_FRAC-1]);
         div_req.start = (state_ff == S_DIV1) || (state_ff == S_DIV2);
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      count_in = count_ff;
      pair_in = pair_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      env_in = env_ff;
      ratio_in = ratio_ff;
      stretch_in = stretch_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      x_in = x_ff;
      lead_in = lead_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      iter_in = iter_ff;
      lmag_in = lmag_ff;
      lneg_in = lneg_ff;
      expo_in = expo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      idx_e = req_data.restart ? 4'd0 : idx_ff;
      len_e = req_data.restart ? 24'd0 : len_ff;
      pos_e = req_data.restart ? 24'd0 : pos_ff;
      len_new = mul_prod[35:12];
      sq_full = mul_prod[63:30];
      tick_val = (mul_prod[63:62] != 2'b00) ? RATIO_MAX : mul_prod[61:30];
      u_val = lneg_ff ? (EXP_BIAS - div_quot[31:0]) : (EXP_BIAS + div_quot[31:0]);
      scaled = {1'b0, m_ff} << 6'(expo_ff - 6'd32);
      n_new = 4'd0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_req.start || div_req.start) begin
         wait_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = idx_e;
               len_in = len_e;
               pos_in = pos_e;
               stretch_in = req_data.stretch;
               if (pos_e < len_e) begin
                  state_in = S_TICK;
               end else if ((n_used >= 4'd2) && (idx_e < n_used - 4'd1)) begin
                  state_in = S_RD0;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_TICK: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               env_in = tick_val;
               pos_in = pos_ff + 24'd1;
               state_in = S_OUT;
            end
         end
         S_RD0: begin
            t0_in = rd_slot[TW-1:0];
            v0_in = rd_slot[16 +: VW];
            // a rising segment from the current one on, the last one apart, cancels the stretch
            if (ahead) begin
               stretch_in = STRETCH_ONE;
            end
            state_in = S_RD1;
         end
         S_RD1: begin
            t1_in = rd_slot[TW-1:0];
            v1_in = rd_slot[16 +: VW];
            state_in = S_LEN;
         end
         S_LEN: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               len_in = len_new;
               pos_in = 24'd0;
               env_in = to_q30(v0_ff);
               idx_in = idx_ff + 4'd1;
               if ((len_new == 24'd0) || (v0_ff == v1_ff)) begin
                  ratio_in = ONE_Q30;
                  state_in = S_OUT;
               end else if (v0_ff == '0) begin
                  ratio_in = RATIO_MAX;
                  state_in = S_OUT;
               end else begin
                  state_in = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (wait_ff && div_done) begin
               wait_in = 1'b0;
               x_in = div_quot + 64'(EPS_Q30);
               lead_in = 6'd63;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // walk the leading one up to bit 63, one place per cycle
            if (x_ff[63]) begin
               m_in = {1'b0, x_ff[63:33]};
               frac_in = '0;
               iter_in = 5'd1;
               state_in = S_SQ;
            end else begin
               x_in = x_ff << 1;
               lead_in = lead_ff - 6'd1;
            end
         end
         S_SQ: begin
            if (wait_ff && mul_done) begin
               wait_in = 1'b0;
               if (sq_full[31]) begin
                  m_in = {1'b0, sq_full[31:1]};
                  frac_in = {frac_ff[LOG_FRAC-2:0], 1'b1};
               end else begin
                  m_in = sq_full[31:0];
                  frac_in = {frac_ff[LOG_FRAC-2:0], 1'b0};
               end
               iter_in = iter_ff + 5'd1;
               if (iter_ff == 5'(LOG_FRAC)) begin
                  // signed log2 kept as sign and magnitude
                  lneg_in = (lead_ff < 6'd30);
                  if (lead_ff < 6'd30) begin
                     lmag_in = (32'(6'd30 - lead_ff) << LOG_FRAC) - 32'(frac_in);
                  end else begin
                     lmag_in = (32'(lead_ff - 6'd30) << LOG_FRAC) + 32'(frac_in);
                  end
                  state_in = S_DIV2;
               end
            end
         end
         S_DIV2: begin
            if (wait_ff && div_done) begin
               wait_in = 1'b0;
               if (!lneg_ff && (div_quot >= Q_HIGH)) begin
                  ratio_in = RATIO_MAX;
                  state_in = S_OUT;
               end else if (lneg_ff && (div_quot > Q_LOW)) begin
                  ratio_in = 32'd0;
                  state_in = S_OUT;
               end else begin
                  frac_in = u_val[LOG_FRAC-1:0];
                  expo_in = u_val[LOG_FRAC +: 6];
                  m_in = ONE_Q30;
                  iter_in = 5'd1;
                  state_in = S_EXP;
               end
            end
         end
         S_EXP: begin
            // fraction bits msb first, multiply by the matching root when set
            if (!frac_ff[LOG_FRAC-1] || (wait_ff && mul_done)) begin
               if (frac_ff[LOG_FRAC-1]) begin
                  wait_in = 1'b0;
                  m_in = mul_prod[61:30];
               end
               frac_in = frac_ff << 1;
               iter_in = iter_ff + 5'd1;
               if (iter_ff == 5'(LOG_FRAC)) begin
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            if (expo_ff >= 6'd32) begin
               ratio_in = scaled[32] ? RATIO_MAX : scaled[31:0];
            end else begin
               ratio_in = m_ff >> (6'd32 - expo_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.level = env_ff[31:16];
               rsp_data_in.done_res = (pos_ff != 24'd0) && (pos_ff == len_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // the user writes only while idle, not enforced; indexes 0..4 restart the envelope
      if (csr_write_en) begin
         unique case (csr_index) inside
            CSR_POINT_COUNT: count_in = csr_wdata[3:0];
            CSR_PAIR_0, CSR_PAIR_1, CSR_PAIR_2, CSR_PAIR_3:
               pair_in[2'(csr_index - CSR_PAIR_0)] = csr_wdata;
            default: ;
         endcase
         if (csr_index <= CSR_PAIR_3) begin
            n_new = clamp_count(count_in);
            idx_in = 4'd0;
            len_in = 24'd0;
            pos_in = 24'd0;
            ratio_in = ONE_Q30;
            if (n_new == 4'd0) begin
               env_in = ONE_Q30;
            end else if ((n_new == 4'd1) || (pair_in[0][TW-1:0] == '0)) begin
               env_in = to_q30(pair_in[0][16 +: VW]);
            end else begin
               env_in = 32'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff <= 1'b0;
         count_ff <= 4'd0;
         pair_ff <= '0;
         idx_ff <= 4'd0;
         len_ff <= 24'd0;
         pos_ff <= 24'd0;
         env_ff <= ONE_Q30;
         ratio_ff <= ONE_Q30;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
         count_ff <= count_in;
         pair_ff <= pair_in;
         idx_ff <= idx_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         env_ff <= env_in;
         ratio_ff <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stretch_ff <= stretch_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      v0_ff <= v0_in;
      v1_ff <= v1_in;
      x_ff <= x_in;
      lead_ff <= lead_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      iter_ff <= iter_in;
      lmag_ff <= lmag_in;
      lneg_ff <= lneg_in;
      expo_ff <= expo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hw/rtl/bpe_checker.sv @@
// port-level checks of the envelope block, bound to the top level
// depends on bpe_pkg and breakpoint_exponential_envelope_top_assert.svh
`timescale 1ns / 1ps

`include "breakpoint_exponential_envelope_top_assert.svh"

module bpe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpe_pkg::rsp_type rsp_data
);
   import bpe_pkg::*;

   // a stalled rsp beat stays up with the same payload
   `BPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped")
   `BPE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "rsp changed")

   // one tick in work at a time
   `BPE_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall, "req taken twice")

   // a result never shows in the cycle right after its accept
   `BPE_ASSERT_NEXT(a_no_early, clock, reset, req_valid && !req_stall, !$rose(rsp_valid),
                    "rsp too early")

   // reset leaves the block empty and ready
   `BPE_ASSERT_NEXT_ALWAYS(a_reset, clock, reset, !rsp_valid && !req_stall, "reset state")

endmodule

bind breakpoint_exponential_envelope_top bpe_checker u_bpe_checker (.*);
